[design/sac_pkg.sv]
// Package for the set-associative tag cache: geometry constants, payload
// structs, line and row layouts, and the control structs between modules.
// No dependencies.
package sac_pkg;

  localparam int ADDR_BITS   = 16;
  localparam int BLOCK_BYTES = 16;
  localparam int NUM_SETS    = 64;
  localparam int WAYS        = 4;

  localparam int OFF_BITS = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 0;
  localparam int SET_BITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_BITS = ADDR_BITS - OFF_BITS - SET_BITS;
  localparam int CNT_BITS = 16;

  localparam logic POL_LRU  = 1'b0;
  localparam logic POL_FIFO = 1'b1;
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [ADDR_BITS-1:0] address;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic [1:0]          way;
    logic [5:0]          set_index;
    logic [CNT_BITS-1:0] hit_count;
  } rsp_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [WAY_BITS-1:0] age;
    logic                valid;
    logic                dirty;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic                last;
    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic [WAY_BITS-1:0] victim;
  } scan_res_t;

endpackage

[design/sac_store.sv]
// Line store of the cache: one memory row per set holding every way's tag,
// age, valid and dirty bits, plus one written flag per set. Uses sac_pkg.
module sac_store (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [sac_pkg::SET_BITS-1:0] rd_set_i,
  input  logic                     wr_en_i,
  input  logic [sac_pkg::SET_BITS-1:0] wr_set_i,
  input  sac_pkg::row_t            wr_row_i,
  output sac_pkg::row_t            rd_row_o
);
  import sac_pkg::*;

  row_t                mem_q [NUM_SETS];
  row_t                raw_q;
  logic [NUM_SETS-1:0] row_written_q;
  logic                seen_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_set_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      raw_q <= mem_q[rd_set_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_written_q <= '0;
      seen_q        <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_written_q[wr_set_i] <= 1'b1;
      end
      if (rd_en_i) begin
        seen_q <= row_written_q[rd_set_i];
      end
    end
  end

  // A set that was never written reads as its reset contents.
  always_comb begin
    rd_row_o = raw_q;
    if (!seen_q) begin
      for (int w = 0; w < WAYS; w++) begin
        rd_row_o[w].valid = 1'b0;
        rd_row_o[w].dirty = 1'b0;
        rd_row_o[w].age   = WAY_BITS'(w);
      end
    end
  end

endmodule

[design/sac_scan.sv]
// Shared way comparator: steps through the ways of one row, one per cycle,
// finding the first valid tag match and the last way of age zero. Uses sac_pkg.
module sac_scan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sac_pkg::scan_ctl_t           ctl_i,
  input  sac_pkg::row_t                row_i,
  input  logic [sac_pkg::TAG_BITS-1:0] tag_i,
  output sac_pkg::scan_res_t           res_o
);
  import sac_pkg::*;

  logic [WAY_BITS-1:0] idx_q;
  logic                hit_q;
  logic [WAY_BITS-1:0] hit_way_q;
  logic [WAY_BITS-1:0] victim_q;
  line_t               line;
  logic                match;
  logic                age_zero;

  assign line     = row_i[idx_q];
  assign match    = line.valid && (line.tag == tag_i);
  assign age_zero = (line.age == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      hit_q     <= 1'b0;
      hit_way_q <= '0;
      victim_q  <= '0;
    end else if (ctl_i.clear) begin
      idx_q     <= '0;
      hit_q     <= 1'b0;
      hit_way_q <= '0;
      victim_q  <= '0;
    end else if (ctl_i.step) begin
      // The lowest matching way wins, the highest way of age zero is the victim.
      if (match && !hit_q) begin
        hit_q     <= 1'b1;
        hit_way_q <= idx_q;
      end
      if (age_zero) begin
        victim_q <= idx_q;
      end
      idx_q <= idx_q + WAY_BITS'(1);
    end
  end

  assign res_o.last    = (idx_q == WAY_BITS'(WAYS - 1));
  assign res_o.hit     = hit_q;
  assign res_o.hit_way = hit_way_q;
  assign res_o.victim  = victim_q;

endmodule

[design/set_assoc_cache_lru_fifo_top.sv]
// Top level of the set-associative tag cache with LRU or FIFO replacement:
// sequencer, row update, hit counter. Uses sac_pkg, sac_store and sac_scan.
//
//   channel   ports                      handshake
//   request   req_i (op, address)        taken when start && !busy
//   result    rsp_o (hit, way, set, cnt) valid for the one cycle done_o is high
//   config    cfg_we_i, cfg_data_i       policy written when cfg_we_i is high
//
// An item runs as follows: the set row is read at the accept edge, the one tag
// comparator then visits a way per cycle, and the update state writes the row
// back and registers the result. done_o rises in the cycle after that, with
// busy already low, so a new item may start then.
// Reset needs no clearing pass: a per-set written flag makes untouched sets
// read as empty with ages equal to way numbers. The receiver cannot stall.
module set_assoc_cache_lru_fifo_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sac_pkg::req_t req_i,
  output logic          done_o,
  output sac_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic          cfg_data_i
);
  import sac_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic                policy_q;
  logic                op_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [SET_BITS-1:0] set_q;
  logic [CNT_BITS-1:0] hits_q, hits_d;
  logic                done_q;
  rsp_t                rsp_q, rsp_d;

  logic                accept;
  logic [SET_BITS-1:0] in_set;
  scan_ctl_t           scan_ctl;
  scan_res_t           scan_res;
  row_t                rd_row;
  row_t                new_row;
  logic                wr_en;
  logic [WAY_BITS-1:0] way;
  logic [WAY_BITS-1:0] prev_age;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign in_set = req_i.address[OFF_BITS +: SET_BITS];
  assign wr_en  = (state_q == ST_UPDATE);

  assign scan_ctl.clear = accept;
  assign scan_ctl.step  = (state_q == ST_SCAN);

  sac_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_set_i (in_set),
    .wr_en_i  (wr_en),
    .wr_set_i (set_q),
    .wr_row_i (new_row),
    .rd_row_o (rd_row)
  );

  sac_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (scan_ctl),
    .row_i  (rd_row),
    .tag_i  (tag_q),
    .res_o  (scan_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_res.last) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Row update for the touched way and the replacement ages of the set.
  always_comb begin
    way      = scan_res.hit ? scan_res.hit_way : scan_res.victim;
    prev_age = rd_row[way].age;
    new_row  = rd_row;
    if (scan_res.hit) begin
      if (op_q == OP_WRITE) begin
        new_row[way].dirty = 1'b1;
      end
    end else begin
      new_row[way].valid = 1'b1;
      new_row[way].tag   = tag_q;
      new_row[way].dirty = (op_q == OP_WRITE);
    end
    for (int w = 0; w < WAYS; w++) begin
      if (policy_q == POL_LRU) begin
        if (WAY_BITS'(w) == way) begin
          new_row[w].age = WAY_BITS'(WAYS - 1);
        end else if (rd_row[w].age > prev_age) begin
          new_row[w].age = rd_row[w].age - WAY_BITS'(1);
        end
      end else if (!scan_res.hit) begin
        if (rd_row[w].age == WAY_BITS'(WAYS - 1)) begin
          new_row[w].age = '0;
        end else begin
          new_row[w].age = rd_row[w].age + WAY_BITS'(1);
        end
      end
    end
  end

  always_comb begin
    hits_d = hits_q;
    if (wr_en && scan_res.hit && (hits_q != '1)) begin
      hits_d = hits_q + CNT_BITS'(1);
    end
    rsp_d.hit       = scan_res.hit;
    rsp_d.way       = 2'(way);
    rsp_d.set_index = 6'(set_q);
    rsp_d.hit_count = hits_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      policy_q <= POL_LRU;
      hits_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      hits_q  <= hits_d;
      done_q  <= wr_en;
      if (cfg_we_i) begin
        policy_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.op;
      tag_q <= req_i.address[ADDR_BITS-1 -: TAG_BITS];
      set_q <= in_set;
    end
    if (wr_en) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef NO_ASSERTIONS
  a_done_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_UPDATE))
    else $error("result strobe without a preceding update cycle");

  a_hits_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hits_q >= $past(hits_q))
    else $error("hit counter went down");

  a_hit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.hit |->
      (hits_q == $past(hits_q) + CNT_BITS'(1)) || ($past(hits_q) == '1))
    else $error("hit did not advance the counter");

  a_miss_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.hit |-> hits_q == $past(hits_q))
    else $error("miss changed the hit counter");
`endif

endmodule
